/* hw/rtl/cht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Shared widths, status codes and the result word type of the hash table core.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int CHT_TABLE_SIZE = 16;
    localparam int KEY_W          = 31;
    localparam int AGE_W          = 16;
    localparam int STATUS_W       = 3;
    localparam int SLOT_W         = 4;

    localparam logic [STATUS_W-1:0] ST_HOME  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COLL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd5;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic MODE_LATE  = 1'b0;
    localparam logic MODE_EARLY = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [AGE_W-1:0]    found_age;
    } cht_result_t;

endpackage

/* hw/rtl/cht_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table slot memory
// Single write port and one registered read port holding the slot records.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 53
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/cht_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table sequencer
// Clears the table, reduces the key to its home slot, walks the chain, writes
// new records and links, and rescans for the highest free slot.
// ----------------------------------------------------------------------------
module cht_ctrl
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = CHT_TABLE_SIZE,
    parameter int IDX_W      = $clog2(TABLE_SIZE),
    parameter int REC_W      = 1 + IDX_W + 1 + KEY_W + AGE_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [KEY_W-1:0]  key,
    input  logic [AGE_W-1:0]  age,
    input  logic              insert_mode,
    output logic              res_valid,
    output cht_result_t       res,
    input  logic              res_take,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output logic [REC_W-1:0]  wr_data,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [REC_W-1:0]  rd_data
);

    localparam int NXT_W = IDX_W + 1;
    localparam logic [NXT_W-1:0] NXT_NONE = {NXT_W{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] TS_LOW = IDX_W'(TABLE_SIZE);
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam int PROD_W = KEY_W + 32;
    localparam int RED_SH = KEY_W + IDX_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RED_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP = 32'(RECIP_L);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_MOD_SUB,
        S_FIND,
        S_WR_NEW,
        S_WR_LINK,
        S_SCAN_RD,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic               kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   home_reg, home_next;
    logic [REC_W-1:0]   home_rec_reg, home_rec_next;
    logic [IDX_W-1:0]   link_addr_reg, link_addr_next;
    logic [REC_W-1:0]   link_rec_reg, link_rec_next;
    logic [IDX_W-1:0]   tgt_reg, tgt_next;
    logic [NXT_W-1:0]   new_nxt_reg, new_nxt_next;
    logic               coll_reg, coll_next;
    logic [IDX_W-1:0]   free_reg, free_next;
    logic               free_none_reg, free_none_next;
    cht_result_t        res_reg, res_next;

    logic               r_valid;
    logic [NXT_W-1:0]   r_nxt;
    logic [KEY_W-1:0]   r_key;
    logic [AGE_W-1:0]   r_age;
    logic [REC_W-1:0]   home_cur;
    logic               match;
    logic [2*IDX_W-1:0] mod_qn;
    logic [IDX_W-1:0]   mod_home;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    assign r_valid  = rd_data[REC_W-1];
    assign r_nxt    = rd_data[REC_W-2 -: NXT_W];
    assign r_key    = rd_data[KEY_W+AGE_W-1 -: KEY_W];
    assign r_age    = rd_data[AGE_W-1:0];
    assign home_cur = (step_reg == '0) ? rd_data : home_rec_reg;
    assign match    = r_valid && (r_key == key_reg);

    assign mod_qn   = prod_reg[RED_SH +: IDX_W] * TS_LOW;
    assign mod_home = key_reg[IDX_W-1:0] - mod_qn[IDX_W-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;
    assign rd_addr   = pos_next;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        age_next       = age_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        home_next      = home_reg;
        home_rec_next  = home_rec_reg;
        link_addr_next = link_addr_reg;
        link_rec_next  = link_rec_reg;
        tgt_next       = tgt_reg;
        new_nxt_next   = new_nxt_reg;
        coll_next      = coll_reg;
        free_next      = free_reg;
        free_none_next = free_none_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = {1'b0, NXT_NONE, {(KEY_W + AGE_W){1'b0}}};

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    key_next  = key;
                    age_next  = age;
                    step_next = '0;
                    if (IS_POW2)
                    begin
                        home_next  = key[IDX_W-1:0];
                        pos_next   = key[IDX_W-1:0];
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                prod_next  = PROD_W'(key_reg) * PROD_W'(RECIP);
                state_next = S_MOD_SUB;
            end
            S_MOD_SUB:
            begin
                home_next  = mod_home;
                pos_next   = mod_home;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (step_reg == '0)
                begin
                    home_rec_next = rd_data;
                end
                if (match)
                begin
                    res_next.status    = (kind_reg == KIND_INSERT) ? ST_DUP : ST_FOUND;
                    res_next.slot      = slot_of(pos_reg);
                    res_next.found_age = r_age;
                    state_next         = S_RESULT;
                end
                else if (!r_valid || r_nxt[NXT_W-1] || (step_reg == LAST_IDX))
                begin
                    res_next.found_age = '0;
                    res_next.slot      = '0;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        res_next.status = ST_MISS;
                        state_next      = S_RESULT;
                    end
                    else if (free_none_reg)
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_RESULT;
                    end
                    else if (!home_cur[REC_W-1])
                    begin
                        res_next.status = ST_HOME;
                        res_next.slot   = slot_of(home_reg);
                        tgt_next        = home_reg;
                        new_nxt_next    = NXT_NONE;
                        coll_next       = 1'b0;
                        state_next      = S_WR_NEW;
                    end
                    else
                    begin
                        res_next.status = ST_COLL;
                        res_next.slot   = slot_of(free_reg);
                        tgt_next        = free_reg;
                        coll_next       = 1'b1;
                        state_next      = S_WR_NEW;
                        if (insert_mode == MODE_EARLY)
                        begin
                            new_nxt_next   = home_cur[REC_W-2 -: NXT_W];
                            link_addr_next = home_reg;
                            link_rec_next  = home_cur;
                        end
                        else
                        begin
                            new_nxt_next   = NXT_NONE;
                            link_addr_next = pos_reg;
                            link_rec_next  = rd_data;
                        end
                    end
                end
                else
                begin
                    pos_next  = r_nxt[IDX_W-1:0];
                    step_next = step_reg + 1'b1;
                end
            end
            S_WR_NEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = tgt_reg;
                wr_data    = {1'b1, new_nxt_reg, key_reg, age_reg};
                state_next = coll_reg ? S_WR_LINK : S_SCAN_RD;
            end
            S_WR_LINK:
            begin
                wr_en      = 1'b1;
                wr_addr    = link_addr_reg;
                wr_data    = {1'b1, 1'b0, tgt_reg,
                              link_rec_reg[KEY_W+AGE_W-1:0]};
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                pos_next   = LAST_IDX;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!r_valid)
                begin
                    free_next      = pos_reg;
                    free_none_next = 1'b0;
                    state_next     = S_RESULT;
                end
                else if (pos_reg == '0)
                begin
                    free_none_next = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_reg      <= LAST_IDX;
            free_none_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            free_none_reg <= free_none_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        age_reg       <= age_next;
        prod_reg      <= prod_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        home_reg      <= home_next;
        home_rec_reg  <= home_rec_next;
        link_addr_reg <= link_addr_next;
        link_rec_reg  <= link_rec_next;
        tgt_reg       <= tgt_next;
        new_nxt_reg   <= new_nxt_next;
        coll_reg      <= coll_next;
        res_reg       <= res_next;
    end

endmodule

/* hw/rtl/coalesced_hash_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalesced hash table core
// Lookup and insert with late or early chaining, one word in the sequencer.
// A lookup result is registered after the chain walk, which reads at most
// TABLE_SIZE slots and is preceded by a home slot reduction when TABLE_SIZE
// is not a power of two; a storing insert adds the new record write, a link
// write on a collision and a rescan of 1 to TABLE_SIZE slots, all set by the
// single slot memory port. The sequencer is ready for the next word in the
// cycle after the result moves to the output register. After reset a clearing
// pass empties every slot of the table before the first word is accepted.
// ----------------------------------------------------------------------------
module coalesced_hash_table_core
    import cht_pkg::*;
#(
    parameter int TABLE_SIZE = CHT_TABLE_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    key,
    input  logic [AGE_W-1:0]    age,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot,
    output logic [AGE_W-1:0]    found_age,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int REC_W = 1 + IDX_W + 1 + KEY_W + AGE_W;

    logic              insert_mode_reg;
    logic              out_valid_reg;
    cht_result_t       out_reg;
    logic              in_ready;
    logic              res_valid;
    cht_result_t       res;
    logic              res_take;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [REC_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [REC_W-1:0]  rd_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = ~in_ready;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign slot      = out_reg.slot;
    assign found_age = out_reg.found_age;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_mode_reg <= MODE_LATE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                insert_mode_reg <= cfg_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    cht_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W),
        .REC_W      (REC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .age         (age),
        .insert_mode (insert_mode_reg),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    cht_ram #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W),
        .DATA_W (REC_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
